// ===== rtl/ccg_pkg.sv =====
// ----------------------------------------------------------------------------
// ccg_pkg
// Types, register addresses, read-back codes and GPIO mode decode helpers
// for the codec control and GPIO interrupt block.
// ----------------------------------------------------------------------------
package ccg_pkg;

  localparam int NUM_PINS       = 8;
  localparam int GPIO_LINES_DEF = 8;

  // beat kinds
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_DATA  = 2'd1;
  localparam logic [1:0] MODE_PIN   = 2'd2;

  // register addresses
  localparam logic [6:0] REG_DAC_CTRL   = 7'h01;
  localparam logic [6:0] REG_POWER      = 7'h14;
  localparam logic [6:0] REG_READ_SEL   = 7'h18;
  localparam logic [6:0] REG_IRQ_POL    = 7'h19;
  localparam logic [6:0] REG_IRQ_MASK   = 7'h1a;
  localparam logic [6:0] REG_GPIO_CTRL1 = 7'h1b;
  localparam logic [6:0] REG_GPIO_CTRL2 = 7'h1c;
  localparam logic [6:0] REG_SOFT_RESET = 7'h1f;
  localparam logic [6:0] REG_MUTE_LEFT  = 7'h31;
  localparam logic [6:0] REG_MUTE_RIGHT = 7'h32;

  // read-back selects
  localparam logic [2:0] RB_ID     = 3'd0;
  localparam logic [2:0] RB_REV    = 3'd1;
  localparam logic [2:0] RB_STATUS = 3'd2;
  localparam logic [2:0] RB_PINS   = 3'd4;
  localparam logic [2:0] RB_IRQ    = 3'd5;

  localparam logic [7:0]  CHIP_ID     = 8'h87;
  localparam logic [7:0]  CHIP_REV    = 8'h53;
  localparam logic [7:0]  CHIP_STATUS = 8'h01;
  localparam logic [8:0]  VALUE_MASK  = 9'h1ff;
  localparam logic [31:0] HALF_RIGHT  = 32'h0000ffff;
  localparam logic [31:0] HALF_LEFT   = 32'hffff0000;
  localparam logic [2:0]  POWER_ON_CODE = 3'd3;

  // line indexes of the configurable GPIO lines
  localparam logic [2:0] GPIO_LINE1 = 3'd1;
  localparam logic [2:0] GPIO_LINE2 = 3'd2;
  localparam logic [2:0] GPIO_LINE3 = 3'd3;
  localparam logic [2:0] GPIO_LINE4 = 3'd4;
  localparam logic [2:0] GPIO_LINE5 = 3'd5;

  typedef enum logic [1:0] {
    LM_INPUT = 2'd0,
    LM_LOW   = 2'd1,
    LM_HIGH  = 2'd2,
    LM_IRQ   = 2'd3
  } line_mode_e;

  typedef struct packed {
    logic [NUM_PINS-1:0] as_input;
    logic [NUM_PINS-1:0] forced_high;
    logic [NUM_PINS-1:0] as_irq;
  } gpio_cfg_t;

  localparam gpio_cfg_t CFG_RESET = '{as_input: '1, forced_high: '0, as_irq: '0};

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
    logic [2:0] gpio_line;
    logic       gpio_level;
  } ccg_item_t;

  typedef struct packed {
    logic [7:0]  irq_levels;
    logic [7:0]  irq_changed;
    logic [7:0]  read_response;
    logic [31:0] in_channel_mask;
    logic [31:0] out_channel_mask;
    logic        codec_enabled;
  } ccg_result_t;

  function automatic line_mode_e decode_hi(input logic [2:0] f);
    line_mode_e m;
    case (f)
      3'd4:    m = LM_LOW;
      3'd5:    m = LM_HIGH;
      3'd7:    m = LM_IRQ;
      default: m = LM_INPUT;
    endcase
    return m;
  endfunction

  function automatic line_mode_e decode_lo(input logic [2:0] f);
    line_mode_e m;
    case (f)
      3'd0:    m = LM_LOW;
      3'd1:    m = LM_HIGH;
      3'd3:    m = LM_IRQ;
      default: m = LM_INPUT;
    endcase
    return m;
  endfunction

  function automatic line_mode_e decode_line5(input logic [1:0] f);
    line_mode_e m;
    case (f)
      2'd0:    m = LM_INPUT;
      2'd1:    m = LM_IRQ;
      2'd2:    m = LM_LOW;
      default: m = LM_HIGH;
    endcase
    return m;
  endfunction

  function automatic gpio_cfg_t set_line_mode(input gpio_cfg_t c, input logic [2:0] line,
                                              input line_mode_e m);
    gpio_cfg_t r;
    r = c;
    r.as_input[line]    = (m == LM_INPUT);
    r.forced_high[line] = (m == LM_HIGH);
    r.as_irq[line]      = (m == LM_IRQ);
    return r;
  endfunction

endpackage

// ===== rtl/ccg_if.sv =====
// ----------------------------------------------------------------------------
// ccg interfaces
// Valid/ready channels for input beats and result beats.
// ----------------------------------------------------------------------------
interface ccg_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] data_byte;
  logic [2:0] gpio_line;
  logic       gpio_level;

  modport source (output valid, mode, data_byte, gpio_line, gpio_level, input ready);
  modport sink   (input valid, mode, data_byte, gpio_line, gpio_level, output ready);
endinterface

interface ccg_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  irq_levels;
  logic [7:0]  irq_changed;
  logic [7:0]  read_response;
  logic [31:0] in_channel_mask;
  logic [31:0] out_channel_mask;
  logic        codec_enabled;

  modport source (output valid, irq_levels, irq_changed, read_response, in_channel_mask,
                  out_channel_mask, codec_enabled, input ready);
  modport sink   (input valid, irq_levels, irq_changed, read_response, in_channel_mask,
                  out_channel_mask, codec_enabled, output ready);
endinterface

// ===== rtl/ccg_in_reg.sv =====
// ----------------------------------------------------------------------------
// ccg_in_reg
// Input register: holds one accepted beat until the core takes it.
// ----------------------------------------------------------------------------
module ccg_in_reg
  import ccg_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  ccg_item_t item_i,
  output logic      ready_o,
  input  logic      take_i,
  output logic      valid_o,
  output ccg_item_t item_o
);

  logic      valid_q, valid_d;
  ccg_item_t item_q;

  // free when empty or being drained this cycle
  assign ready_o = !valid_q || take_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== rtl/ccg_core.sv =====
// ----------------------------------------------------------------------------
// ccg_core
// Register decode, GPIO mode and interrupt state, and result build for one
// beat per cycle whenever step_i is asserted.
// ----------------------------------------------------------------------------
module ccg_core
  import ccg_pkg::*;
#(
  parameter int GPIO_LINES = GPIO_LINES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  ccg_item_t   item_i,
  output ccg_result_t res_o
);

  localparam logic [1:0] CNT_IDLE  = 2'd0;
  localparam logic [1:0] CNT_FIRST = 2'd1;
  localparam logic [1:0] CNT_DONE  = 2'd2;
  localparam logic [NUM_PINS-1:0] LINE_MASK = NUM_PINS'((1 << GPIO_LINES) - 1);

  logic [1:0]          cnt_q, cnt_d;
  logic [7:0]          first_q, first_d;
  logic [7:0]          resp_q, resp_d;
  logic [NUM_PINS-1:0] pol_q, pol_d;
  logic [NUM_PINS-1:0] msk_q, msk_d;
  logic                en_q, en_d;
  logic [NUM_PINS-1:0] pin_q, pin_d;
  gpio_cfg_t           cfg_q, cfg_d;
  logic [NUM_PINS-1:0] driven_q, driven_d;
  logic                mute_l_q, mute_l_d;
  logic                mute_r_q, mute_r_d;
  logic                dac_mute_q, dac_mute_d;
  logic                power_q, power_d;

  logic [6:0]          wr_addr;
  logic [8:0]          wr_value;
  logic [NUM_PINS-1:0] pending_cur, pending_upd, lvl;
  logic [7:0]          rb_byte;
  logic                drive_upd;
  logic                line_ok;
  logic [31:0]         mask_l, mask_r, dmask;

  assign wr_addr     = first_q[7:1];
  assign wr_value    = {first_q[0], item_i.data_byte} & VALUE_MASK;
  assign pending_cur = cfg_q.as_input & (pin_q ^ pol_q) & msk_q;
  assign line_ok     = int'(item_i.gpio_line) < GPIO_LINES;

  // read-back sees the state as it stood before this write
  always_comb begin
    case (wr_value[3:1])
      RB_ID:     rb_byte = CHIP_ID;
      RB_REV:    rb_byte = CHIP_REV;
      RB_STATUS: rb_byte = CHIP_STATUS;
      RB_PINS:   rb_byte = (cfg_q.as_input & pin_q) | cfg_q.forced_high;
      RB_IRQ:    rb_byte = en_q ? pending_cur : '0;
      default:   rb_byte = '0;
    endcase
  end

  always_comb begin
    cnt_d      = cnt_q;
    first_d    = first_q;
    resp_d     = resp_q;
    pol_d      = pol_q;
    msk_d      = msk_q;
    en_d       = en_q;
    pin_d      = pin_q;
    cfg_d      = cfg_q;
    mute_l_d   = mute_l_q;
    mute_r_d   = mute_r_q;
    dac_mute_d = dac_mute_q;
    power_d    = power_q;
    drive_upd  = 1'b0;
    case (item_i.mode)
      MODE_START: cnt_d = CNT_IDLE;
      MODE_DATA: begin
        if (cnt_q == CNT_IDLE) begin
          first_d = item_i.data_byte;
          cnt_d   = CNT_FIRST;
        end else if (cnt_q == CNT_FIRST) begin
          cnt_d = CNT_DONE;
          case (wr_addr)
            REG_DAC_CTRL: dac_mute_d = wr_value[3];
            REG_POWER:    power_d = (wr_value[8:6] == POWER_ON_CODE);
            REG_READ_SEL: resp_d = rb_byte;
            REG_IRQ_POL: begin
              pol_d     = wr_value[7:0];
              drive_upd = 1'b1;
            end
            REG_IRQ_MASK: begin
              msk_d     = wr_value[7:0];
              drive_upd = 1'b1;
            end
            REG_GPIO_CTRL1: begin
              en_d      = |wr_value[1:0];
              cfg_d     = set_line_mode(cfg_d, GPIO_LINE5, decode_line5(wr_value[4:3]));
              cfg_d     = set_line_mode(cfg_d, GPIO_LINE4, decode_hi(wr_value[2:0]));
              drive_upd = 1'b1;
            end
            REG_GPIO_CTRL2: begin
              cfg_d     = set_line_mode(cfg_d, GPIO_LINE3, decode_hi(wr_value[8:6]));
              cfg_d     = set_line_mode(cfg_d, GPIO_LINE2, decode_lo(wr_value[5:3]));
              cfg_d     = set_line_mode(cfg_d, GPIO_LINE1, decode_lo(wr_value[2:0]));
              drive_upd = 1'b1;
            end
            REG_SOFT_RESET: begin
              if (wr_value == '0) begin
                pol_d      = '0;
                msk_d      = '0;
                en_d       = 1'b0;
                cfg_d      = CFG_RESET;
                mute_l_d   = 1'b0;
                mute_r_d   = 1'b0;
                dac_mute_d = 1'b1;
                power_d    = 1'b0;
                drive_upd  = 1'b1;
              end
            end
            REG_MUTE_LEFT:  mute_l_d = wr_value[7];
            REG_MUTE_RIGHT: mute_r_d = wr_value[7];
            default: ;
          endcase
        end
      end
      MODE_PIN: begin
        if (line_ok) begin
          pin_d[item_i.gpio_line] = item_i.gpio_level;
          drive_upd               = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // driven levels from the updated state
  assign pending_upd = cfg_d.as_input & (pin_d ^ pol_d) & msk_d;
  assign lvl         = (cfg_d.forced_high | ((en_d && |pending_upd) ? cfg_d.as_irq : '0)) &
                       LINE_MASK;
  assign driven_d    = drive_upd ? lvl : driven_q;

  assign mask_l = mute_l_d ? HALF_RIGHT : '1;
  assign mask_r = mute_r_d ? HALF_LEFT : '1;
  assign dmask  = dac_mute_d ? '0 : '1;

  always_comb begin
    res_o.irq_levels       = driven_d;
    res_o.irq_changed      = drive_upd ? (lvl ^ driven_q) : '0;
    res_o.read_response    = resp_d;
    res_o.in_channel_mask  = mask_l & mask_r & dmask;
    res_o.out_channel_mask = dmask;
    res_o.codec_enabled    = power_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= CNT_IDLE;
      first_q    <= '0;
      resp_q     <= '0;
      pol_q      <= '0;
      msk_q      <= '0;
      en_q       <= 1'b0;
      pin_q      <= '0;
      cfg_q      <= CFG_RESET;
      driven_q   <= '0;
      mute_l_q   <= 1'b0;
      mute_r_q   <= 1'b0;
      dac_mute_q <= 1'b1;
      power_q    <= 1'b0;
    end else if (step_i) begin
      cnt_q      <= cnt_d;
      first_q    <= first_d;
      resp_q     <= resp_d;
      pol_q      <= pol_d;
      msk_q      <= msk_d;
      en_q       <= en_d;
      pin_q      <= pin_d;
      cfg_q      <= cfg_d;
      driven_q   <= driven_d;
      mute_l_q   <= mute_l_d;
      mute_r_q   <= mute_r_d;
      dac_mute_q <= dac_mute_d;
      power_q    <= power_d;
    end
  end

endmodule

// ===== rtl/codec_control_gpio_irq.sv =====
// an accepted input beat is held in the input register, then the result register, before out_o
// throughput: one beat per cycle; input register, decode core and result
// register advance together whenever the result register is empty or drained
// reset: asynchronous, active low; codec state returns to power-up values
// (all lines input, DAC muted, codec off) and both channels empty
// ----------------------------------------------------------------------------
// codec_control_gpio_irq
// Codec control register interface with GPIO modes and interrupt lines.
// ----------------------------------------------------------------------------
module codec_control_gpio_irq
  import ccg_pkg::*;
#(
  parameter int GPIO_LINES = GPIO_LINES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ccg_in_if.sink     in_i,
  ccg_out_if.source  out_o
);

  ccg_item_t   in_item, s1_item;
  ccg_result_t core_res, res_q;
  logic        s1_valid, step;
  logic        oval_q, oval_d;

  assign in_item = '{mode: in_i.mode, data_byte: in_i.data_byte,
                     gpio_line: in_i.gpio_line, gpio_level: in_i.gpio_level};

  // core steps when the result register has room
  assign step = s1_valid && (!oval_q || out_o.ready);

  ccg_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .item_i  (in_item),
    .ready_o (in_i.ready),
    .take_i  (step),
    .valid_o (s1_valid),
    .item_o  (s1_item)
  );

  ccg_core #(
    .GPIO_LINES (GPIO_LINES)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (s1_item),
    .res_o  (core_res)
  );

  always_comb begin
    if (step) begin
      oval_d = 1'b1;
    end else if (out_o.ready) begin
      oval_d = 1'b0;
    end else begin
      oval_d = oval_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oval_q <= 1'b0;
    end else begin
      oval_q <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= core_res;
    end
  end

  assign out_o.valid            = oval_q;
  assign out_o.irq_levels       = res_q.irq_levels;
  assign out_o.irq_changed      = res_q.irq_changed;
  assign out_o.read_response    = res_q.read_response;
  assign out_o.in_channel_mask  = res_q.in_channel_mask;
  assign out_o.out_channel_mask = res_q.out_channel_mask;
  assign out_o.codec_enabled    = res_q.codec_enabled;

endmodule

// ===== rtl/ccg_checker.sv =====
// ----------------------------------------------------------------------------
// ccg_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module ccg_checker
  import ccg_pkg::*;
#(
  parameter int GPIO_LINES = GPIO_LINES_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [7:0]  irq_levels_i,
  input logic [7:0]  irq_changed_i,
  input logic [7:0]  read_response_i,
  input logic [31:0] in_mask_i,
  input logic [31:0] out_mask_i,
  input logic        enabled_i
);

  localparam logic [NUM_PINS-1:0] LINE_MASK = NUM_PINS'((1 << GPIO_LINES) - 1);

  logic       out_beat;
  logic [7:0] last_levels_q;

  assign out_beat = out_valid_i && out_ready_i;

  // driven levels of the previous result beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_levels_q <= '0;
    end else if (out_beat) begin
      last_levels_q <= irq_levels_i;
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(irq_levels_i) &&
      $stable(irq_changed_i) && $stable(read_response_i) && $stable(in_mask_i) &&
      $stable(out_mask_i) && $stable(enabled_i))
    else $error("result beat changed while stalled");

  a_change_trail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat |-> ((irq_levels_i ^ last_levels_q) == irq_changed_i))
    else $error("change mask disagrees with level history");

  a_levels_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((irq_levels_i & ~LINE_MASK) == '0))
    else $error("level driven on a line that does not exist");

  a_dac_mask_whole: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_mask_i == '0) || (out_mask_i == '1))
    else $error("DAC mask is neither open nor shut");

  a_adc_within_dac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((in_mask_i & ~out_mask_i) == '0))
    else $error("ADC mask open while DAC muted");

endmodule

bind codec_control_gpio_irq ccg_checker #(
  .GPIO_LINES (GPIO_LINES)
) u_ccg_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .irq_levels_i    (out_o.irq_levels),
  .irq_changed_i   (out_o.irq_changed),
  .read_response_i (out_o.read_response),
  .in_mask_i       (out_o.in_channel_mask),
  .out_mask_i      (out_o.out_channel_mask),
  .enabled_i       (out_o.codec_enabled)
);
